[hdl/rtprc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rtprc_pkg;

    // Datagram size limit; bytes beyond it are dropped as if truncated.
    localparam int MAX_PACKET_BYTES = 1500;
    localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int SIZE_W           = 19;
    localparam int NUM_RECV         = 4;
    localparam int CFG_IDX_W        = 3;

    typedef logic [CNT_W-1:0] cnt_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SSRC_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SSRC_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SSRC_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SSRC_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAGS  = 3'd4;

    // Record kinds
    localparam logic KIND_APP     = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Header constants
    localparam logic [7:0] TYPE_SR         = 8'd200;
    localparam logic [7:0] TYPE_RR         = 8'd201;
    localparam logic [7:0] TYPE_SDES       = 8'd202;
    localparam logic [7:0] TYPE_APP        = 8'd204;
    localparam logic [6:0] RTP_PT_LOW_MAX  = 7'd34;
    localparam logic [6:0] RTP_PT_HIGH_MIN = 7'd96;
    localparam logic [1:0] RTP_VERSION     = 2'd2;
    localparam int         MIN_DGRAM_BYTES = 12;
    localparam int         MIN_APP_BYTES   = 24;

    typedef enum logic [1:0] {
        CLASS_SMALL   = 2'd0,
        CLASS_RTP     = 2'd1,
        CLASS_RTCP    = 2'd2,
        CLASS_UNKNOWN = 2'd3
    } pkt_class_t;

    typedef struct packed {
        logic [NUM_RECV-1:0][31:0] ssrc;
        logic [NUM_RECV-1:0]       valid;
        logic [NUM_RECV-1:0]       is_rtcp;
    } recv_cfg_t;

    typedef struct packed {
        logic       record_kind;
        pkt_class_t packet_class;
        logic [31:0] stream_ssrc;
        logic       receiver_found;
        logic [1:0] receiver_index;
        logic [4:0] app_subtype;
        logic [31:0] app_sender_ssrc;
        logic [31:0] app_name;
        logic [31:0] app_target_ssrc;
        logic [31:0] app_timestamp;
        logic       last_of_run;
    } rec_t;

    function automatic logic is_rtp_type(input logic [7:0] t);
        return (t[6:0] <= RTP_PT_LOW_MAX) || (t[6:0] >= RTP_PT_HIGH_MIN);
    endfunction

    function automatic logic is_rtcp_type(input logic [7:0] t);
        return (t == TYPE_SR) || (t == TYPE_RR) || (t == TYPE_SDES);
    endfunction

endpackage

`default_nettype wire

[hdl/rtprc_parse.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtprc_parse
    import rtprc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire logic [7:0] data_byte,
    input  wire logic      end_of_datagram,
    input  wire recv_cfg_t recv_cfg,
    output logic [1:0]     res_cnt,
    output rec_t           res0,
    output rec_t           res1
);

    cnt_t              byte_count_reg, byte_count_next;
    logic [7:0]        type_byte_reg, type_byte_next;
    logic [31:0]       header_ssrc_reg, header_ssrc_next;
    logic              walk_active_reg, walk_active_next;
    cnt_t              sub_start_reg, sub_start_next;
    logic [SIZE_W-1:0] sub_size_reg, sub_size_next;
    logic [7:0]        sub_first_reg, sub_first_next;
    logic [7:0]        sub_type_reg, sub_type_next;
    logic [3:0][31:0]  sub_words_reg, sub_words_next;

    cnt_t       pos;
    cnt_t       rel;
    cnt_t       rel_m4;
    logic [1:0] word_sel;
    logic       take;
    logic       walk;
    cnt_t       start;
    logic       app_done;
    logic [16:0] len_words;

    pkt_class_t cls;
    logic [31:0] v_ssrc;
    logic       want_rtcp;
    logic       found;
    logic [1:0] idx;
    rec_t       app_rec;
    rec_t       verdict_rec;

    // Per-byte header capture and compound walk
    always_comb
    begin
        pos              = byte_count_reg;
        take             = (pos < CNT_W'(MAX_PACKET_BYTES));
        byte_count_next  = byte_count_reg;
        type_byte_next   = type_byte_reg;
        header_ssrc_next = header_ssrc_reg;
        walk             = walk_active_reg;
        start            = sub_start_reg;
        sub_size_next    = sub_size_reg;
        sub_first_next   = sub_first_reg;
        sub_type_next    = sub_type_reg;
        sub_words_next   = sub_words_reg;
        rel              = '0;
        rel_m4           = '0;
        word_sel         = '0;
        app_done         = 1'b0;
        len_words        = {1'b0, sub_size_reg[7:0], data_byte} + 17'd1;

        if (take)
        begin
            if (pos == CNT_W'(1))
                type_byte_next = data_byte;
            if ((pos >= CNT_W'(4) && pos <= CNT_W'(7) && is_rtcp_type(type_byte_next)) ||
                (pos >= CNT_W'(8) && pos <= CNT_W'(11) && is_rtp_type(type_byte_next)))
                header_ssrc_next = {header_ssrc_reg[23:0], data_byte};

            if (pos == '0)
            begin
                walk  = 1'b1;
                start = '0;
            end
            rel    = pos - start;
            rel_m4 = rel - CNT_W'(4);
            if (walk)
            begin
                priority if (rel == CNT_W'(0))
                begin
                    sub_first_next = data_byte;
                    sub_size_next  = '0;
                    sub_words_next = '0;
                    walk           = (data_byte[7:6] == RTP_VERSION);
                end
                else if (rel == CNT_W'(1))
                    sub_type_next = data_byte;
                else if (rel == CNT_W'(2))
                    sub_size_next = SIZE_W'(data_byte);
                else if (rel == CNT_W'(3))
                    sub_size_next = {len_words, 2'b00};
                else if (rel <= CNT_W'(19))
                begin
                    word_sel = rel_m4[3:2];
                    sub_words_next[word_sel] = {sub_words_reg[word_sel][23:0], data_byte};
                end
                else
                begin
                    // past the four body words: nothing captured
                end

                // sub-packet completes on this byte
                if (walk && rel >= CNT_W'(3) &&
                    SIZE_W'(rel) == sub_size_next - SIZE_W'(1))
                begin
                    app_done = is_rtcp_type(type_byte_next) &&
                               (sub_type_next == TYPE_APP) &&
                               (sub_size_next >= SIZE_W'(MIN_APP_BYTES));
                    start    = pos + CNT_W'(1);
                end
            end
            byte_count_next = pos + CNT_W'(1);
        end
    end

    // Verdict class and receiver lookup
    always_comb
    begin
        want_rtcp = 1'b0;
        v_ssrc    = '0;
        if (byte_count_next < CNT_W'(MIN_DGRAM_BYTES))
            cls = CLASS_SMALL;
        else if (is_rtp_type(type_byte_next))
            cls = CLASS_RTP;
        else if (is_rtcp_type(type_byte_next))
        begin
            cls       = CLASS_RTCP;
            want_rtcp = 1'b1;
        end
        else
            cls = CLASS_UNKNOWN;

        if (cls == CLASS_RTP || cls == CLASS_RTCP)
            v_ssrc = header_ssrc_next;

        found = 1'b0;
        idx   = '0;
        if (cls == CLASS_RTP || cls == CLASS_RTCP)
        begin
            for (int i = NUM_RECV - 1; i >= 0; i--)
            begin
                if (recv_cfg.valid[i] && (recv_cfg.is_rtcp[i] == want_rtcp) &&
                    (recv_cfg.ssrc[i] == v_ssrc))
                begin
                    found = 1'b1;
                    idx   = 2'(i);
                end
            end
        end
    end

    always_comb
    begin
        app_rec                 = '0;
        app_rec.record_kind     = KIND_APP;
        app_rec.packet_class    = CLASS_RTCP;
        app_rec.app_subtype     = sub_first_next[4:0];
        app_rec.app_sender_ssrc = sub_words_next[0];
        app_rec.app_name        = sub_words_next[1];
        app_rec.app_target_ssrc = sub_words_next[2];
        app_rec.app_timestamp   = sub_words_next[3];
        app_rec.last_of_run     = !end_of_datagram;

        verdict_rec                = '0;
        verdict_rec.record_kind    = KIND_VERDICT;
        verdict_rec.packet_class   = cls;
        verdict_rec.stream_ssrc    = v_ssrc;
        verdict_rec.receiver_found = found;
        verdict_rec.receiver_index = idx;
        verdict_rec.last_of_run    = 1'b1;

        res_cnt = {1'b0, app_done} + {1'b0, end_of_datagram};
        res0    = app_done ? app_rec : verdict_rec;
        res1    = verdict_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            type_byte_reg   <= '0;
            header_ssrc_reg <= '0;
            walk_active_reg <= 1'b0;
            sub_start_reg   <= '0;
            sub_size_reg    <= '0;
            sub_first_reg   <= '0;
            sub_type_reg    <= '0;
            sub_words_reg   <= '0;
        end
        else if (step)
        begin
            if (end_of_datagram)
            begin
                // datagram done: start clean
                byte_count_reg  <= '0;
                type_byte_reg   <= '0;
                header_ssrc_reg <= '0;
                walk_active_reg <= 1'b0;
                sub_start_reg   <= '0;
                sub_size_reg    <= '0;
                sub_first_reg   <= '0;
                sub_type_reg    <= '0;
                sub_words_reg   <= '0;
            end
            else
            begin
                byte_count_reg  <= byte_count_next;
                type_byte_reg   <= type_byte_next;
                header_ssrc_reg <= header_ssrc_next;
                walk_active_reg <= walk_active_next;
                sub_start_reg   <= sub_start_next;
                sub_size_reg    <= sub_size_next;
                sub_first_reg   <= sub_first_next;
                sub_type_reg    <= sub_type_next;
                sub_words_reg   <= sub_words_next;
            end
        end
    end

    assign walk_active_next = take ? walk : walk_active_reg;
    assign sub_start_next   = take ? start : sub_start_reg;

endmodule

`default_nettype wire

[hdl/rtprc_outq.sv]
`timescale 1ns / 1ps
`default_nettype none

// Two-entry result queue; takes up to two records per cycle.
module rtprc_outq
    import rtprc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic [1:0] push_cnt,
    input  wire rec_t      push0,
    input  wire rec_t      push1,
    output logic [1:0]     free_cnt,
    output logic           head_valid,
    input  wire logic      head_ready,
    output rec_t           head
);

    rec_t       q_reg [2];
    logic [1:0] count_reg, count_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       pop;

    assign head_valid = (count_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];
    assign pop        = head_valid && head_ready;
    assign free_cnt   = 2'd2 - count_reg;

    always_comb
    begin
        count_next  = count_reg + push_cnt - {1'b0, pop};
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push_cnt[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            q_reg[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            q_reg[!wr_ptr_reg] <= push1;
    end

endmodule

`default_nettype wire

[hdl/rtp_rtcp_packet_classifier.sv]
// RTP/RTCP datagram classifier.
// Input stream (s_*): one datagram byte per request, s_tlast on the final byte.
// Output stream (m_*): result records. m_tuser is the record kind (APP record
// or datagram verdict), m_tlast marks the last record caused by one byte.
// Every datagram yields one verdict on its final byte; each complete RTCP APP
// sub-packet yields an APP record on the byte that completes it, ahead of
// the verdict when both fall on the same byte.
// Config (cfg_*): index 0..3 receiver SSRCs, index 4 flags (valid bits 3:0,
// RTCP-kind bits 7:4). Write only while the block is idle; cfg_ready is
// always high.
// A byte lands in the input register, is classified combinationally there,
// and its records are written into the result queue that drives m_*.
// Throughput: one byte per cycle while the result queue has room for its
// records; a byte that produces two records needs an empty two-entry result
// queue, which can hold the input even when the output drains at full rate.
// A stalled receiver fills the result queue, then the input register, and
// s_tready drops. Reset clears the datagram state, the queue and all config.
`timescale 1ns / 1ps
`default_nettype none

module rtp_rtcp_packet_classifier
    import rtprc_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    // input bytes
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,   // [7:0] data_byte
    input  wire logic           s_tlast,   // end_of_datagram
    // result records
    output logic                m_tvalid,
    input  wire logic           m_tready,
    // [1:0] packet_class, [33:2] stream_ssrc, [34] receiver_found,
    // [36:35] receiver_index, [41:37] app_subtype, [73:42] app_sender_ssrc,
    // [105:74] app_name, [137:106] app_target_ssrc, [169:138] app_timestamp,
    // [175:170] zero
    output logic [175:0]        m_tdata,
    output logic [0:0]          m_tuser,   // [0] record_kind
    output logic                m_tlast,   // last_of_run
    // configuration writes
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]    cfg_data
);

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       s_accept;
    logic       advance;

    // Receiver table
    logic [NUM_RECV-1:0][31:0] recv_ssrc_reg;
    logic [7:0]                recv_flags_reg;
    recv_cfg_t                 recv_cfg;

    logic [1:0] res_cnt;
    rec_t       res0;
    rec_t       res1;
    logic [1:0] free_cnt;
    rec_t       head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_ssrc_reg  <= '0;
            recv_flags_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SSRC_0: recv_ssrc_reg[0] <= cfg_data;
                CFG_SSRC_1: recv_ssrc_reg[1] <= cfg_data;
                CFG_SSRC_2: recv_ssrc_reg[2] <= cfg_data;
                CFG_SSRC_3: recv_ssrc_reg[3] <= cfg_data;
                CFG_FLAGS:  recv_flags_reg   <= cfg_data[7:0];
                default:    ;  // unmapped index, ignored
            endcase
        end
    end

    assign recv_cfg.ssrc    = recv_ssrc_reg;
    assign recv_cfg.valid   = recv_flags_reg[3:0];
    assign recv_cfg.is_rtcp = recv_flags_reg[7:4];

    // Byte moves on only when the queue has room for all its records;
    // s_tready does not look at m_tready.
    assign advance  = in_valid_reg && (res_cnt <= free_cnt);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    rtprc_parse u_parse (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .data_byte       (in_byte_reg),
        .end_of_datagram (in_last_reg),
        .recv_cfg        (recv_cfg),
        .res_cnt         (res_cnt),
        .res0            (res0),
        .res1            (res1)
    );

    rtprc_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (advance ? res_cnt : 2'd0),
        .push0      (res0),
        .push1      (res1),
        .free_cnt   (free_cnt),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    assign m_tdata = {6'd0,
                      head.app_timestamp,
                      head.app_target_ssrc,
                      head.app_name,
                      head.app_sender_ssrc,
                      head.app_subtype,
                      head.receiver_index,
                      head.receiver_found,
                      head.stream_ssrc,
                      head.packet_class};
    assign m_tuser = head.record_kind;
    assign m_tlast = head.last_of_run;

endmodule

`default_nettype wire
